// ===== rtl/sbd_pkg.sv =====
// Shared types and constants for the signed multi-limb divider.
`timescale 1ns / 1ps
`default_nettype none

package sbd_pkg;

  // Width of one limb of the operands and results.
  localparam int LIMB_W = 63;

  // Operation codes carried on the last input transaction.
  localparam logic OP_DIVIDE = 1'b0;
  localparam logic OP_MODULO = 1'b1;

  typedef logic [LIMB_W-1:0] sbd_limb_t;

  // One input transaction: a limb pair plus operation and end marker.
  typedef struct packed {
    logic      operation;
    sbd_limb_t dividend_limb;
    sbd_limb_t divisor_limb;
    logic      last_limb;
  } sbd_in_t;

  // One result transaction.
  typedef struct packed {
    sbd_limb_t result_limb;
    logic      result_last;
    logic      divide_by_zero;
  } sbd_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ALIGN,
    ST_MAG,
    ST_DIV,
    ST_OUT
  } sbd_state_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic load_wr;
    logic rot_store;
    logic capture_op;
    logic mag;
    logic div_step;
    logic pass_end;
    logic out_step;
    logic first_limb;
    logic last_limb;
  } sbd_ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic d_zero;
    logic out_ready;
  } sbd_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sbd_ctrl.sv =====
// Sequencer for the divider: load, align, magnitude, division passes and output.
`timescale 1ns / 1ps
`default_nettype none

module sbd_ctrl
  import sbd_pkg::*;
#(
  parameter int LIMBS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  input  sbd_stat_t stat,
  output logic      in_stall,
  output sbd_ctrl_t ctl
);

  localparam int CW = $clog2(LIMBS + 1);
  localparam int K  = LIMB_W * LIMBS;
  localparam int PW = $clog2(K);

  sbd_state_t      state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic [PW-1:0]   pass_r, pass_nxt;
  logic            accept;
  logic            cnt_full;
  logic            cnt_first;
  logic            cnt_last;

  assign cnt_inc   = cnt_r + 1'b1;
  assign cnt_full  = (cnt_r == CW'(LIMBS));
  assign cnt_first = (cnt_r == '0);
  assign cnt_last  = (cnt_r == CW'(LIMBS - 1));
  assign in_stall  = (state_r != ST_LOAD);
  assign accept    = in_valid && (state_r == ST_LOAD);

  // Next state, counters and datapath strobes.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    ctl       = '0;
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          // Limbs beyond the store depth are dropped.
          ctl.load_wr   = !cnt_full;
          ctl.rot_store = !cnt_full;
          if (!cnt_full) begin
            cnt_nxt = cnt_inc;
          end
          if (in_last) begin
            ctl.capture_op = 1'b1;
            if (cnt_full || (cnt_inc == CW'(LIMBS))) begin
              state_nxt = ST_MAG;
              cnt_nxt   = '0;
            end else begin
              state_nxt = ST_ALIGN;
            end
          end
        end
      end
      ST_ALIGN: begin
        // Finish a full turn of the store lines after an early last transaction.
        ctl.rot_store = 1'b1;
        cnt_nxt       = cnt_inc;
        if (cnt_inc == CW'(LIMBS)) begin
          state_nxt = ST_MAG;
          cnt_nxt   = '0;
        end
      end
      ST_MAG: begin
        ctl.mag        = 1'b1;
        ctl.rot_store  = 1'b1;
        ctl.first_limb = cnt_first;
        ctl.last_limb  = cnt_last;
        cnt_nxt        = cnt_inc;
        if (cnt_last) begin
          cnt_nxt   = '0;
          pass_nxt  = '0;
          state_nxt = stat.d_zero ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV: begin
        ctl.div_step   = 1'b1;
        ctl.first_limb = cnt_first;
        ctl.last_limb  = cnt_last;
        cnt_nxt        = cnt_inc;
        if (cnt_last) begin
          ctl.pass_end = 1'b1;
          cnt_nxt      = '0;
          pass_nxt     = pass_r + 1'b1;
          if (pass_r == PW'(K - 1)) begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (stat.out_ready) begin
          ctl.out_step   = 1'b1;
          ctl.rot_store  = 1'b1;
          ctl.first_limb = cnt_first;
          ctl.last_limb  = cnt_last;
          cnt_nxt        = cnt_inc;
          if (cnt_last) begin
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        cnt_nxt   = '0;
      end
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pass_r  <= pass_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sbd_dp.sv =====
// Limb-serial datapath: rotating limb lines, limb-wide adders and an output register.
`timescale 1ns / 1ps
`default_nettype none

module sbd_dp
  import sbd_pkg::*;
#(
  parameter int LIMBS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  sbd_ctrl_t ctl,
  input  sbd_in_t   in_data,
  output sbd_stat_t stat,
  output logic      out_valid,
  input  logic      out_stall,
  output sbd_out_t  out_data
);

  // Rotating limb lines: position 0 is the limb under work.
  sbd_limb_t dst_r [LIMBS];
  sbd_limb_t dst_nxt [LIMBS];
  sbd_limb_t sst_r [LIMBS];
  sbd_limb_t sst_nxt [LIMBS];
  sbd_limb_t aq_r [LIMBS];
  sbd_limb_t aq_nxt [LIMBS];
  sbd_limb_t dm_r [LIMBS];
  sbd_limb_t dm_nxt [LIMBS];
  sbd_limb_t ra_r [LIMBS];
  sbd_limb_t ra_nxt [LIMBS];
  sbd_limb_t rb_r [LIMBS];
  sbd_limb_t rb_nxt [LIMBS];

  logic       sel_r, sel_nxt;
  logic       carry_r, carry_nxt;
  logic       borrow_r, borrow_nxt;
  logic       cya_r, cya_nxt;
  logic       cyd_r, cyd_nxt;
  logic       ocy_r, ocy_nxt;
  logic       op_r, op_nxt;
  logic       dnz_r, dnz_nxt;
  logic       dz_r, dz_nxt;
  logic       snz_r, snz_nxt;
  logic       fnz_r, fnz_nxt;
  logic       rnz_r, rnz_nxt;
  logic [1:0] signs_r, signs_nxt;
  logic       out_valid_r, out_valid_nxt;
  sbd_out_t   out_data_r, out_data_nxt;

  logic              sa, sd;
  logic [LIMB_W:0]   mag_a, mag_d;
  logic              dnz_cur;
  sbd_limb_t         cur, s_lim;
  logic              sin, bin, ge;
  logic [LIMB_W:0]   dif;
  logic              snz_cur, fnz_cur;
  logic              inv, ocin, ozero;
  sbd_limb_t         oa, ob;
  logic [LIMB_W:0]   osum;

  // Magnitude pass: conditional two's complement negation, one limb per cycle.
  assign sa = ctl.first_limb ? dst_r[LIMBS-1][LIMB_W-1] : signs_r[0];
  assign sd = ctl.first_limb ? sst_r[LIMBS-1][LIMB_W-1] : signs_r[1];
  assign mag_a = {1'b0, (sa ? ~dst_r[0] : dst_r[0])}
               + {{LIMB_W{1'b0}}, (ctl.first_limb ? sa : cya_r)};
  assign mag_d = {1'b0, (sd ? ~sst_r[0] : sst_r[0])}
               + {{LIMB_W{1'b0}}, (ctl.first_limb ? sd : cyd_r)};
  assign dnz_cur = (ctl.first_limb ? 1'b0 : dnz_r) | (|mag_d[LIMB_W-1:0]);

  // Division step: shift the partial remainder left one bit and trial subtract.
  assign cur     = sel_r ? rb_r[0] : ra_r[0];
  assign sin     = ctl.first_limb ? aq_r[LIMBS-1][LIMB_W-1] : carry_r;
  assign s_lim   = {cur[LIMB_W-2:0], sin};
  assign bin     = ctl.first_limb ? 1'b0 : borrow_r;
  assign dif     = {1'b0, s_lim} - {1'b0, dm_r[0]} - {{LIMB_W{1'b0}}, bin};
  assign ge      = !dif[LIMB_W];
  assign snz_cur = (ctl.first_limb ? 1'b0 : snz_r) | (|s_lim);
  assign fnz_cur = (ctl.first_limb ? 1'b0 : fnz_r) | (|dif[LIMB_W-1:0]);

  // Result fix-up: sign correction of the quotient or remainder.
  always_comb begin
    if (op_r == OP_DIVIDE) begin
      inv = signs_r[0] ^ signs_r[1];
      oa  = '0;
      ob  = aq_r[0];
    end else begin
      inv = signs_r[0];
      oa  = (signs_r[0] ^ signs_r[1]) ? sst_r[0] : '0;
      ob  = cur;
    end
  end
  assign ocin  = ctl.first_limb ? inv : ocy_r;
  assign osum  = {1'b0, oa} + {1'b0, (inv ? ~ob : ob)} + {{LIMB_W{1'b0}}, ocin};
  assign ozero = dz_r || ((op_r == OP_MODULO) && !rnz_r);

  assign stat.d_zero    = !dnz_cur;
  assign stat.out_ready = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

  // Next values of all lines and flags.
  always_comb begin
    dst_nxt       = dst_r;
    sst_nxt       = sst_r;
    aq_nxt        = aq_r;
    dm_nxt        = dm_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    sel_nxt       = sel_r;
    carry_nxt     = carry_r;
    borrow_nxt    = borrow_r;
    cya_nxt       = cya_r;
    cyd_nxt       = cyd_r;
    ocy_nxt       = ocy_r;
    op_nxt        = op_r;
    dnz_nxt       = dnz_r;
    dz_nxt        = dz_r;
    snz_nxt       = snz_r;
    fnz_nxt       = fnz_r;
    rnz_nxt       = rnz_r;
    signs_nxt     = signs_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    // Operand stores turn one limb per step; a new limb enters at the top.
    if (ctl.rot_store) begin
      for (int i = 0; i < LIMBS - 1; i++) begin
        dst_nxt[i] = dst_r[i+1];
        sst_nxt[i] = sst_r[i+1];
      end
      dst_nxt[LIMBS-1] = ctl.load_wr ? in_data.dividend_limb : dst_r[0];
      sst_nxt[LIMBS-1] = ctl.load_wr ? in_data.divisor_limb : sst_r[0];
    end

    if (ctl.capture_op) begin
      op_nxt = in_data.operation;
    end

    // Build magnitudes and clear the remainder.
    if (ctl.mag) begin
      for (int i = 0; i < LIMBS - 1; i++) begin
        aq_nxt[i] = aq_r[i+1];
        dm_nxt[i] = dm_r[i+1];
        ra_nxt[i] = ra_r[i+1];
      end
      aq_nxt[LIMBS-1] = mag_a[LIMB_W-1:0];
      dm_nxt[LIMBS-1] = mag_d[LIMB_W-1:0];
      ra_nxt[LIMBS-1] = '0;
      cya_nxt = mag_a[LIMB_W];
      cyd_nxt = mag_d[LIMB_W];
      dnz_nxt = dnz_cur;
      sel_nxt = 1'b0;
      if (ctl.first_limb) begin
        signs_nxt = {sd, sa};
      end
      if (ctl.last_limb) begin
        dz_nxt = !dnz_cur;
      end
    end

    // One limb of a quotient bit: shifted value goes to the live remainder
    // line, the difference to the spare one; the final borrow picks the winner.
    if (ctl.div_step) begin
      for (int i = 0; i < LIMBS - 1; i++) begin
        ra_nxt[i] = ra_r[i+1];
        rb_nxt[i] = rb_r[i+1];
        dm_nxt[i] = dm_r[i+1];
      end
      ra_nxt[LIMBS-1] = sel_r ? dif[LIMB_W-1:0] : s_lim;
      rb_nxt[LIMBS-1] = sel_r ? s_lim : dif[LIMB_W-1:0];
      dm_nxt[LIMBS-1] = dm_r[0];
      carry_nxt  = cur[LIMB_W-1];
      borrow_nxt = dif[LIMB_W];
      snz_nxt    = snz_cur;
      fnz_nxt    = fnz_cur;
      if (ctl.pass_end) begin
        sel_nxt   = sel_r ^ ge;
        rnz_nxt   = ge ? fnz_cur : snz_cur;
        aq_nxt[0] = {aq_r[0][LIMB_W-2:0], ge};
        for (int i = 1; i < LIMBS; i++) begin
          aq_nxt[i] = {aq_r[i][LIMB_W-2:0], aq_r[i-1][LIMB_W-1]};
        end
      end
    end

    // Emit one corrected result limb per transaction.
    if (ctl.out_step) begin
      for (int i = 0; i < LIMBS - 1; i++) begin
        aq_nxt[i] = aq_r[i+1];
        ra_nxt[i] = ra_r[i+1];
        rb_nxt[i] = rb_r[i+1];
      end
      aq_nxt[LIMBS-1] = aq_r[0];
      ra_nxt[LIMBS-1] = ra_r[0];
      rb_nxt[LIMBS-1] = rb_r[0];
      ocy_nxt = osum[LIMB_W];
      out_data_nxt.result_limb    = ozero ? '0 : osum[LIMB_W-1:0];
      out_data_nxt.result_last    = ctl.last_limb;
      out_data_nxt.divide_by_zero = dz_r;
    end

    // Output register holds until the transaction is taken.
    if (ctl.out_step) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    dst_r      <= dst_nxt;
    sst_r      <= sst_nxt;
    aq_r       <= aq_nxt;
    dm_r       <= dm_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    sel_r      <= sel_nxt;
    carry_r    <= carry_nxt;
    borrow_r   <= borrow_nxt;
    cya_r      <= cya_nxt;
    cyd_r      <= cyd_nxt;
    ocy_r      <= ocy_nxt;
    op_r       <= op_nxt;
    dnz_r      <= dnz_nxt;
    dz_r       <= dz_nxt;
    snz_r      <= snz_nxt;
    fnz_r      <= fnz_nxt;
    rnz_r      <= rnz_nxt;
    signs_r    <= signs_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/signed_bigint_divider.sv =====
// Top level of the signed multi-limb divider.
// Loading takes one transaction per cycle, LIMBS limb pairs per operand set.
// After the last pair: an align phase after an early last pair, the magnitude phase,
// the division phase (one pass of the single limb subtractor over all limbs per
// quotient bit, none for a zero divisor), then LIMBS result transactions, one per
// unstalled cycle. Reset clears the sequencer and output valid only.
`timescale 1ns / 1ps
`default_nettype none

module signed_bigint_divider
  import sbd_pkg::*;
#(
  parameter int LIMBS = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sbd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sbd_out_t out_data
);

  sbd_ctrl_t ctl;
  sbd_stat_t stat;

  // Sequencer.
  sbd_ctrl #(
    .LIMBS(LIMBS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_limb),
    .stat     (stat),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  // Limb-serial datapath.
  sbd_dp #(
    .LIMBS(LIMBS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/signed_bigint_divider_checker.sv =====
// Checker for the signed multi-limb divider: predicts result transactions and compares them.
`timescale 1ns / 1ps

module signed_bigint_divider_checker
  import sbd_pkg::*;
#(
  parameter int LIMBS = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  sbd_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  sbd_out_t out_data,
  output int       mismatch_count,
  output int       awaited_count
);

  localparam int WIDE_W = LIMB_W * LIMBS;

  typedef logic [WIDE_W-1:0] wide_t;

  // Own copy of the operand stores and the load position.
  sbd_limb_t dividend_limbs [LIMBS];
  sbd_limb_t divisor_limbs [LIMBS];
  int        fill_count;

  // Result limbs still to come, oldest first.
  sbd_out_t  awaited_limbs [$];

  initial begin
    mismatch_count = 0;
    awaited_count  = 0;
    fill_count     = 0;
  end

  // Stores one limb pair; a closing pair divides and queues the result limbs.
  task automatic absorb_pair(input sbd_in_t t);
    wide_t    num;
    wide_t    den;
    wide_t    num_mag;
    wide_t    den_mag;
    wide_t    quo;
    wide_t    rem;
    wide_t    res;
    logic     num_neg;
    logic     den_neg;
    logic     zero_div;
    sbd_out_t want;
    int       i;
    if (fill_count < LIMBS) begin
      dividend_limbs[fill_count] = t.dividend_limb;
      divisor_limbs[fill_count]  = t.divisor_limb;
    end
    if (!t.last_limb) begin
      if (fill_count < LIMBS) begin
        fill_count++;
      end
      return;
    end
    fill_count = 0;

    for (i = 0; i < LIMBS; i++) begin
      num[i*LIMB_W +: LIMB_W] = dividend_limbs[i];
      den[i*LIMB_W +: LIMB_W] = divisor_limbs[i];
    end
    num_neg  = num[WIDE_W-1];
    den_neg  = den[WIDE_W-1];
    num_mag  = num_neg ? -num : num;
    den_mag  = den_neg ? -den : den;
    zero_div = (den_mag == '0);
    res      = '0;

    if (!zero_div) begin
      quo = num_mag / den_mag;
      rem = num_mag % den_mag;
      if (t.operation == OP_DIVIDE) begin
        res = (num_neg ^ den_neg) ? -quo : quo;
      end else if (rem != '0) begin
        // The remainder takes the sign of the divisor.
        case ({den_neg, num_neg})
          2'b00: begin
            res = rem;
          end
          2'b10: begin
            res = den + rem;
          end
          2'b01: begin
            res = den - rem;
          end
          default: begin
            res = -rem;
          end
        endcase
      end
    end

    for (i = 0; i < LIMBS; i++) begin
      want.result_limb    = res[i*LIMB_W +: LIMB_W];
      want.result_last    = (i == LIMBS - 1);
      want.divide_by_zero = zero_div;
      awaited_limbs.push_back(want);
    end
    awaited_count = awaited_limbs.size();
  endtask

  // Compares one result transaction with the oldest awaited limb.
  task automatic check_result(input sbd_out_t got);
    sbd_out_t want;
    if (awaited_limbs.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result transaction: expected none, got %h", $time, got);
      return;
    end
    want = awaited_limbs.pop_front();
    awaited_count = awaited_limbs.size();
    if (got.result_limb !== want.result_limb) begin
      mismatch_count++;
      $display("%0t: result_limb mismatch: expected %h, got %h",
               $time, want.result_limb, got.result_limb);
    end
    if (got.result_last !== want.result_last) begin
      mismatch_count++;
      $display("%0t: result_last mismatch: expected %b, got %b",
               $time, want.result_last, got.result_last);
    end
    if (got.divide_by_zero !== want.divide_by_zero) begin
      mismatch_count++;
      $display("%0t: divide_by_zero mismatch: expected %b, got %b",
               $time, want.divide_by_zero, got.divide_by_zero);
    end
  endtask

  // Watch both channels; a result never follows an input in the same cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
      end
      if (in_valid && !in_stall) begin
        absorb_pair(in_data);
      end
    end
  end

endmodule

// ===== tb/signed_bigint_divider_test.sv =====
// Testbench top for the signed multi-limb divider: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module signed_bigint_divider_test
  import sbd_pkg::*;
();

  localparam int LIMBS        = 4;
  localparam int WIDE_W       = LIMB_W * LIMBS;
  localparam int RANDOM_ITEMS = 330;
  localparam int DRAIN_CYCLES = 63 * LIMBS * LIMBS + 8 * LIMBS;
  localparam int CYCLE_LIMIT  = 2_000_000;

  typedef logic [WIDE_W-1:0] wide_t;

  localparam wide_t MOST_NEG  = {1'b1, {(WIDE_W-1){1'b0}}};
  localparam wide_t MOST_POS  = ~MOST_NEG;
  localparam wide_t MINUS_ONE = '1;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  sbd_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sbd_out_t out_data;

  int       mismatch_count;
  int       awaited_count;
  int       idle_pct  = 0;
  int       stall_pct = 0;
  int       fed_items = 0;
  int       cycle_count = 0;
  logic     primed    = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  signed_bigint_divider #(
    .LIMBS(LIMBS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  signed_bigint_divider_checker #(
    .LIMBS(LIMBS)
  ) limb_watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .awaited_count (awaited_count)
  );

  // Random backpressure on the result channel.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("signed_bigint_divider_test: done, errors");
      $finish;
    end
  end

  function automatic sbd_limb_t draw_limb();
    return sbd_limb_t'({$urandom, $urandom});
  endfunction

  // Operand value: random, with extremes and short magnitudes mixed in.
  function automatic wide_t draw_value();
    wide_t v;
    v = '0;
    repeat ((WIDE_W + 31) / 32) v = (v << 32) | wide_t'($urandom);
    case ($urandom_range(11))
      0: begin
        v = '0;
      end
      1: begin
        v = wide_t'(1);
      end
      2: begin
        v = MINUS_ONE;
      end
      3: begin
        v = MOST_NEG;
      end
      4: begin
        v = MOST_POS;
      end
      5, 6, 7: begin
        v = v >> $urandom_range(WIDE_W - 1);
        if ($urandom_range(1)) begin
          v = -v;
        end
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  // Presents one transaction, with random idle cycles ahead of it.
  task automatic send_item(input sbd_in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sends the low depth limb pairs; spill adds ignored pairs, the final one closing.
  task automatic send_operation(input wide_t num, input wide_t den, input logic op,
                                input int depth, input int spill);
    sbd_in_t item;
    int      i;
    for (i = 0; i < depth + spill; i++) begin
      item.dividend_limb = draw_limb();
      item.divisor_limb  = draw_limb();
      if (i < LIMBS) begin
        item.dividend_limb = num[i*LIMB_W +: LIMB_W];
        item.divisor_limb  = den[i*LIMB_W +: LIMB_W];
      end
      item.last_limb = (i == depth + spill - 1);
      item.operation = item.last_limb ? op : logic'($urandom_range(1));
      send_item(item);
    end
    fed_items += depth;
    if (depth == LIMBS) begin
      primed = 1'b1;
    end
  endtask

  initial begin
    wide_t num;
    wide_t den;
    int    depth;
    int    spill;
    int    shape;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases: wrap of the most negative quotient, modulo signs,
    // early close, zero divisor, and an overlong operand with zero remainder.
    send_operation(MOST_NEG, MINUS_ONE, OP_DIVIDE, LIMBS, 0);
    send_operation(-wide_t'(7), wide_t'(2), OP_MODULO, LIMBS, 0);
    send_operation(wide_t'(7), -wide_t'(2), OP_MODULO, LIMBS, 0);
    send_operation(-wide_t'(7), -wide_t'(2), OP_MODULO, 1, 0);
    send_operation(MOST_POS, '0, OP_DIVIDE, LIMBS, 0);
    send_operation(MOST_POS, wide_t'(1), OP_MODULO, LIMBS, 2);

    // Random operations over four flow-control phases.
    fed_items = 0;
    while (fed_items < RANDOM_ITEMS) begin
      case (fed_items * 4 / RANDOM_ITEMS)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 75;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 75;
        end
        default: begin
          idle_pct = 32;
          stall_pct <= 32;
        end
      endcase

      den = draw_value();
      case ($urandom_range(5))
        0: begin
          num = den * wide_t'($urandom_range(1000));
        end
        1: begin
          num = den;
        end
        default: begin
          num = draw_value();
        end
      endcase

      // Mostly well-formed operands; some close early, some run long.
      depth = LIMBS;
      spill = 0;
      shape = $urandom_range(9);
      if (shape == 0 && primed) begin
        depth = $urandom_range(LIMBS - 1, 1);
      end else if (shape == 1) begin
        spill = $urandom_range(3, 1);
      end
      send_operation(num, den, logic'($urandom_range(1)), depth, spill);
    end
    in_valid <= 1'b0;

    // Drain, then allow time for any stray result.
    do @(negedge clk); while (awaited_count != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("signed_bigint_divider_test: done, clean");
    end else begin
      $display("signed_bigint_divider_test: done, errors");
    end
    $finish;
  end

endmodule
